// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deque RTL; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge while out of reset.
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define RBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/rbd_pkg.sv =====
// Types, operation codes and sizes for the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int ITEM_BITS = 3;
    localparam int OP_BITS   = 3;
    localparam int CNT_BITS  = 4;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_PEEK_FRONT = 3'd3;
    localparam logic [OP_BITS-1:0] OP_STATUS     = 3'd4;

    typedef logic [ITEM_BITS-1:0] item_t;

    typedef struct packed {
        logic [OP_BITS-1:0] operation;
        item_t              item_in;
    } rbd_in_t;

    typedef struct packed {
        logic                ok;
        item_t               item_out;
        logic                is_empty;
        logic                is_full;
        logic [CNT_BITS-1:0] count;
    } rbd_out_t;

    // Per-cycle moves that every cell sees
    typedef struct packed {
        logic push_back;
        logic push_front;
        logic pop_front;
    } rbd_ctrl_t;

endpackage

// ===== rtl/rbd_cell.sv =====
// One storage cell of the deque row: loads, shifts toward front or back, or holds.
module rbd_cell
    import rbd_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 4
) (
    input  logic             aclk,
    input  rbd_ctrl_t        ctrl,
    input  logic [CNT_W-1:0] fill,
    input  item_t            item_in,
    input  item_t            from_front,
    input  item_t            from_back,
    output item_t            item_q
);

    item_t item_reg;
    item_t item_next;

    // Shift back on push front, shift forward on pop, load the first free cell on push back
    always_comb begin
        item_next = item_reg;
        if (ctrl.push_front) begin
            item_next = from_front;
        end else if (ctrl.pop_front) begin
            item_next = from_back;
        end else if (ctrl.push_back && (fill == CNT_W'(INDEX))) begin
            item_next = item_in;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_q = item_reg;

endmodule

// ===== rtl/ring_buffer_deque_top.sv =====
// Top level of the ring buffer deque: control, cell row and result register.
//
//  channel | ports                      | direction | payload
//  --------+----------------------------+-----------+-------------------------------------
//  s_      | s_valid s_ready s_data     | in        | operation, item_in
//  m_      | m_valid m_ready m_data     | out       | ok, item_out, is_empty, is_full, count
//
// One transaction per cycle while m_ready keeps the output drained: the cell row shifts or loads and the
// result lands in a single output register the cycle after acceptance.
// s_ready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) empties the deque; cell contents are not cleared.
// A stall on m_ready holds the result and blocks new input until it is taken.
module ring_buffer_deque_top
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rbd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rbd_out_t m_data
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    rbd_out_t         m_data_reg;
    rbd_out_t         res;
    rbd_ctrl_t        ctrl;
    logic             accept;
    logic             full;
    logic             empty;
    item_t            cell_q [DEPTH];

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // Decode the operation and form the result
    always_comb begin
        ctrl         = '0;
        count_next   = count_reg;
        res          = '0;
        case (s_data.operation)
            OP_PUSH_BACK: begin
                if (!full) begin
                    res.ok         = 1'b1;
                    ctrl.push_back = accept;
                    count_next     = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (!full) begin
                    res.ok          = 1'b1;
                    ctrl.push_front = accept;
                    count_next      = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!empty) begin
                    res.ok         = 1'b1;
                    res.item_out   = cell_q[0];
                    ctrl.pop_front = accept;
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_PEEK_FRONT: begin
                if (!empty) begin
                    res.ok       = 1'b1;
                    res.item_out = cell_q[0];
                end
            end
            OP_STATUS: begin
                res.ok = 1'b1;
            end
            default: begin
                res.ok = 1'b0;
            end
        endcase
        res.is_empty = (count_next == '0);
        res.is_full  = (count_next == CNT_W'(DEPTH));
        res.count    = CNT_BITS'(count_next);
    end

    // Row of cells, front at index zero
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        item_t from_front;
        item_t from_back;
        if (i == 0) begin : g_first
            assign from_front = s_data.item_in;
        end else begin : g_mid_f
            assign from_front = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign from_back = s_data.item_in;
        end else begin : g_mid_b
            assign from_back = cell_q[i+1];
        end
        rbd_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .fill       (count_reg),
            .item_in    (s_data.item_in),
            .from_front (from_front),
            .from_back  (from_back),
            .item_q     (cell_q[i])
        );
    end

    // Advance occupancy and hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RBD_ASSERT_ALWAYS(a_count_range, aclk,
        !aresetn || (count_reg <= CNT_W'(DEPTH)), "occupancy above depth")
    `RBD_ASSERT(a_count_hold, aclk, aresetn,
        !accept |=> $stable(count_reg), "count moved with no transaction")
    `RBD_ASSERT(a_push_inc, aclk, aresetn,
        (accept && ctrl.push_back) |=> (count_reg == $past(count_reg) + 1'b1),
        "push back did not grow count")
    `RBD_ASSERT(a_pop_item, aclk, aresetn,
        (accept && ctrl.pop_front) |=> (m_data_reg.item_out == $past(cell_q[0])),
        "pop returned wrong front item")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the ring buffer deque top level.
`timescale 1ns / 1ps

module tb_top
    import rbd_pkg::*;
;

    localparam int DEPTH = DEPTH_DEF;
    localparam int HOLD_CYCLES = 80;

    // Operation mix used by the random traffic
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rbd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rbd_out_t m_data;

    ring_buffer_deque_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the deque contents and pointers
    item_t    shadow_slots [DEPTH];
    int       shadow_head;
    int       shadow_tail;
    int       shadow_fill;

    rbd_out_t predicted_replies [$];
    rbd_out_t want;
    int       mismatches;
    bit       offering;
    int       burst_left;
    bit       hold_req;
    int       hold_left;
    int       rx_mode;
    int       rx_mode_left;
    int       rx_phase;

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Give up if the run hangs
    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Work out the reply for one accepted transaction and advance the shadow state
    function automatic rbd_out_t predict_reply(rbd_in_t tx);
        rbd_out_t r;
        r = '0;
        case (tx.operation)
            OP_PUSH_BACK: begin
                if (shadow_fill < DEPTH) begin
                    shadow_slots[shadow_tail] = tx.item_in;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (shadow_fill < DEPTH) begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_head] = tx.item_in;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_fill != 0) begin
                    r.item_out = shadow_slots[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
            OP_PEEK_FRONT: begin
                if (shadow_fill != 0) begin
                    r.item_out = shadow_slots[shadow_head];
                    r.ok = 1'b1;
                end
            end
            OP_STATUS: begin
                r.ok = 1'b1;
            end
            default: begin
                // Reserved codes leave the deque alone and report failure
            end
        endcase
        r.is_empty = (shadow_fill == 0);
        r.is_full  = (shadow_fill >= DEPTH);
        r.count    = CNT_BITS'(shadow_fill);
        return r;
    endfunction

    // Offer one transaction, hold it until accepted, then maybe pause
    task automatic send_op(input rbd_in_t tx);
        s_data <= tx;
        if (!offering) begin
            s_valid <= 1'b1;
            offering = 1'b1;
        end
        do @(posedge aclk); while (!s_ready);
        predicted_replies.push_back(predict_reply(tx));
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_code(input logic [OP_BITS-1:0] op, input item_t item);
        rbd_in_t tx;
        tx.operation = op;
        tx.item_in   = item;
        send_op(tx);
    endtask

    // Stop offering and wait for every outstanding reply
    task automatic settle();
        int waited;
        waited = 0;
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (predicted_replies.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (predicted_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
            mismatches += predicted_replies.size();
            predicted_replies.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    // Draw one operation; the mix steers the deque toward full, empty, or neither
    function automatic rbd_in_t random_op(int mix);
        rbd_in_t tx;
        int      roll;
        int      push_pct;
        int      pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
            MIX_DRAIN: begin push_pct = 20; pop_pct = 55; end
            default:   begin push_pct = 45; pop_pct = 35; end
        endcase
        tx.item_in = item_t'($urandom);
        if (roll < push_pct) begin
            tx.operation = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (roll < push_pct + pop_pct) begin
            tx.operation = OP_POP_FRONT;
        end else if (roll < 92) begin
            tx.operation = OP_PEEK_FRONT;
        end else if (roll < 96) begin
            tx.operation = OP_STATUS;
        end else begin
            tx.operation = OP_BITS'($urandom_range(OP_STATUS + 1, 2**OP_BITS - 1));
        end
        return tx;
    endfunction

    // Refusals on an empty deque, status, reserved codes, front push wrapping below zero
    task automatic test_empty_ops();
        send_code(OP_POP_FRONT, '0);
        send_code(OP_PEEK_FRONT, '1);
        send_code(OP_STATUS, '0);
        for (int c = OP_STATUS + 1; c < 2**OP_BITS; c++) begin
            send_code(OP_BITS'(c), item_t'(c));
        end
        send_code(OP_PUSH_FRONT, '1);
        send_code(OP_PEEK_FRONT, '0);
        send_code(OP_POP_FRONT, '0);
        settle();
    endtask

    // Fill to the top with every item code, then try both pushes, a status and a peek while full
    task automatic test_full_ops();
        for (int v = 0; v < DEPTH; v++) begin
            send_code(OP_PUSH_BACK, item_t'(v));
        end
        send_code(OP_PUSH_BACK, '1);
        send_code(OP_PUSH_FRONT, '0);
        send_code(OP_STATUS, '1);
        send_code(OP_PEEK_FRONT, '1);
        settle();
    endtask

    // Pop and push at the front of the deque left full by the previous test, then peek
    task automatic test_mixed_ends();
        send_code(OP_POP_FRONT, '0);
        send_code(OP_POP_FRONT, '0);
        send_code(OP_PUSH_FRONT, item_t'(6));
        send_code(OP_PUSH_FRONT, item_t'(1));
        send_code(OP_PEEK_FRONT, '0);
        settle();
    endtask

    // Long random traffic with phases that swing between full and empty
    task automatic test_random_traffic(input int n_items);
        int mix;
        int phase_left;
        mix = MIX_EVEN;
        phase_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (phase_left == 0) begin
                mix = $urandom_range(MIX_FILL, MIX_EVEN);
                phase_left = $urandom_range(15, 60);
            end
            phase_left--;
            send_op(random_op(mix));
        end
        settle();
    endtask

    // Hold the receiver off for a long stretch while input keeps coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_op(random_op(MIX_EVEN));
        end
        settle();
    endtask

    // Receiver: switch between stall patterns, or obey a long hold-off
    initial begin
        m_ready = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        rx_phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(16, 64);
                end
                rx_mode_left--;
                rx_phase = (rx_phase + 1) % 3;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (rx_phase == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Compare each accepted reply with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: reply with nothing outstanding, expected none, got %p",
                         $time, m_data);
                mismatches++;
            end else begin
                want = predicted_replies.pop_front();
                check_field("ok", 32'(want.ok), 32'(m_data.ok));
                check_field("item_out", 32'(want.item_out), 32'(m_data.item_out));
                check_field("is_empty", 32'(want.is_empty), 32'(m_data.is_empty));
                check_field("is_full", 32'(want.is_full), 32'(m_data.is_full));
                check_field("count", 32'(want.count), 32'(m_data.count));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        mismatches = 0;
        offering = 1'b0;
        burst_left = $urandom_range(1, 10);
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_ops();
        test_full_ops();
        test_mixed_ends();
        test_random_traffic(300);
        test_backpressure();
        test_random_traffic(300);

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== ring_buffer_deque_top.f =====
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_cell.sv
rtl/ring_buffer_deque_top.sv
tb/sv/tb_top.sv
